>>> hw/rtl/arc_pkg.sv
// Package for the axis response curve block: full scale, widths, curve and
// register codes, control structs and the elaboration-time tangent table builder.
// No dependencies.
package arc_pkg;

  localparam int unsigned FULL_SCALE = 350;
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned SENS_W     = 16;
  localparam int unsigned MAG_W      = 9;
  localparam int unsigned PROD_W     = SENS_W + RAW_W;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned OUT_W      = 10;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned IDX_W      = 3;

  // floor(2^26 / FULL_SCALE): quotient of a square by full scale is exact to within one
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / FULL_SCALE);

  typedef enum logic [2:0] {
    CURVE_LINEAR   = 3'd0,
    CURVE_SQUARED  = 3'd1,
    CURVE_TAN      = 3'd2,
    CURVE_TAN_SQ   = 3'd3,
    CURVE_TAN_CUBE = 3'd4
  } curve_t;

  typedef enum logic [IDX_W-1:0] {
    REG_POS_SENS  = 3'd0,
    REG_NEG_SENS  = 3'd1,
    REG_POS_CURVE = 3'd2,
    REG_NEG_CURVE = 3'd3,
    REG_POS_GATE  = 3'd4,
    REG_NEG_GATE  = 3'd5,
    REG_INVERT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SENS_W-1:0] pos_sens;
    logic [SENS_W-1:0] neg_sens;
    logic [2:0]        pos_curve;
    logic [2:0]        neg_curve;
    logic [MAG_W-1:0]  pos_gate;
    logic [MAG_W-1:0]  neg_gate;
    logic              invert;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       code;
    logic [MAG_W-1:0] gate;
    logic             neg;
  } ctrl_t;

  typedef logic [MAG_W-1:0] tan_rom_t [0:FULL_SCALE];

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // unsigned quotient by shift and subtract
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned quot;
    longint unsigned rest;
    quot = 0;
    rest = 0;
    for (int i = 63; i >= 0; i--) begin
      rest = {rest[62:0], n[i]};
      quot = quot << 1;
      if (rest >= d) begin
        rest = rest - d;
        quot = quot | 64'd1;
      end
    end
    return quot;
  endfunction

  // floor(F * tan(a)) for a in Q30, from truncated Q30 Taylor sums, saturated at F
  function automatic logic [MAG_W-1:0] tan_mag(input longint unsigned a);
    longint unsigned s;
    longint unsigned st;
    longint unsigned c;
    longint unsigned ct;
    longint unsigned r;
    longint unsigned k;
    s  = a;
    st = a;
    c  = Q30_ONE;
    ct = Q30_ONE;
    for (k = 1; k <= 7; k++) begin
      st = udiv((((st * a) >> 30) * a) >> 30, (2 * k) * (2 * k + 1));
      ct = udiv((((ct * a) >> 30) * a) >> 30, (2 * k - 1) * (2 * k));
      if (k[0]) begin
        s = (s >= st) ? s - st : 64'd0;
        c = (c >= ct) ? c - ct : 64'd0;
      end else begin
        s = s + st;
        c = c + ct;
      end
    end
    if (c == 0) begin
      r = FULL_SCALE;
    end else begin
      r = udiv(longint'(FULL_SCALE) * s, c);
    end
    if (r > FULL_SCALE) begin
      r = FULL_SCALE;
    end
    return MAG_W'(r);
  endfunction

  // table of tan_mag over m = 0..F with argument (m/F)^power
  function automatic tan_rom_t build_tan_rom(input int unsigned power);
    tan_rom_t        rom;
    longint unsigned num;
    longint unsigned den;
    longint unsigned a;
    for (int unsigned m = 0; m <= FULL_SCALE; m++) begin
      num = 1;
      den = 1;
      for (int unsigned p = 0; p < power; p++) begin
        num = num * longint'(m);
        den = den * longint'(FULL_SCALE);
      end
      a = udiv(num << 30, den);
      rom[m] = tan_mag(a);
    end
    return rom;
  endfunction

endpackage

>>> hw/rtl/arc_scale.sv
// Scaling front end of the axis response curve: direction select, gain multiply,
// clamp to full scale and square of the clamped magnitude. Two register stages.
// Depends on arc_pkg.
module arc_scale import arc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_raw,
  input  cfg_t                    cfg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [MAG_W-1:0]        out_mag,
  output logic [SQ_W-1:0]         out_sq,
  output ctrl_t                   out_ctrl
);

  logic              vld_a_r;
  logic [PROD_W-1:0] prod_a_r;
  ctrl_t             ctrl_a_r;
  logic              vld_b_r;
  logic [MAG_W-1:0]  mag_b_r;
  logic [SQ_W-1:0]   sq_b_r;
  ctrl_t             ctrl_b_r;

  logic              ready_a;
  logic              ready_b;
  logic              neg;
  logic              pos;
  logic [RAW_W-1:0]  raw_u;
  logic [RAW_W-1:0]  mag;
  logic [SENS_W-1:0] sens;
  ctrl_t             ctrl_nxt;
  logic [PROD_W-9:0] scaled;
  logic [MAG_W-1:0]  mag_nxt;

  assign ready_b  = !vld_b_r || out_ready;
  assign ready_a  = !vld_a_r || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    raw_u         = RAW_W'(in_raw);
    neg           = raw_u[RAW_W-1];
    pos           = !neg && (raw_u != '0);
    mag           = neg ? (RAW_W'(0) - raw_u) : raw_u;
    sens          = pos ? cfg.pos_sens : cfg.neg_sens;
    ctrl_nxt.code = pos ? cfg.pos_curve : cfg.neg_curve;
    ctrl_nxt.gate = pos ? cfg.pos_gate : cfg.neg_gate;
    ctrl_nxt.neg  = neg ^ cfg.invert;
  end

  always_comb begin
    scaled  = prod_a_r[PROD_W-1:8];
    mag_nxt = (scaled > (PROD_W-8)'(FULL_SCALE)) ? MAG_W'(FULL_SCALE) : scaled[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (ready_a) begin
        vld_a_r <= in_valid;
      end
      if (ready_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      prod_a_r <= PROD_W'(sens) * PROD_W'(mag);
      ctrl_a_r <= ctrl_nxt;
    end
    if (ready_b && vld_a_r) begin
      mag_b_r  <= mag_nxt;
      sq_b_r   <= SQ_W'(mag_nxt) * SQ_W'(mag_nxt);
      ctrl_b_r <= ctrl_a_r;
    end
  end

  assign out_valid = vld_b_r;
  assign out_mag   = mag_b_r;
  assign out_sq    = sq_b_r;
  assign out_ctrl  = ctrl_b_r;

endmodule

>>> hw/rtl/arc_curve.sv
// Curve stage of the axis response curve: tangent magnitude tables, reciprocal
// divide of the square by full scale and curve select. Two register stages.
// Depends on arc_pkg.
module arc_curve import arc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MAG_W-1:0] in_mag,
  input  logic [SQ_W-1:0]  in_sq,
  input  ctrl_t            in_ctrl,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [MAG_W-1:0] out_curve,
  output ctrl_t            out_ctrl
);

  localparam tan_rom_t TAN1_ROM = build_tan_rom(1);
  localparam tan_rom_t TAN2_ROM = build_tan_rom(2);
  localparam tan_rom_t TAN3_ROM = build_tan_rom(3);
  localparam int unsigned QP_W  = SQ_W + RECIP_W;

  logic             vld_c_r;
  logic [MAG_W-1:0] mag_c_r;
  logic [SQ_W-1:0]  sq_c_r;
  logic [MAG_W-1:0] q0_c_r;
  logic [MAG_W-1:0] tan_c_r;
  ctrl_t            ctrl_c_r;
  logic             vld_d_r;
  logic [MAG_W-1:0] curve_d_r;
  ctrl_t            ctrl_d_r;

  logic             ready_c;
  logic             ready_d;
  logic [QP_W-1:0]  qprod;
  logic [MAG_W-1:0] tan_nxt;
  logic [SQ_W-1:0]  rem;
  logic [MAG_W-1:0] qsq;
  logic [MAG_W-1:0] curve_nxt;

  assign ready_d  = !vld_d_r || out_ready;
  assign ready_c  = !vld_c_r || ready_d;
  assign in_ready = ready_c;

  always_comb begin
    qprod = QP_W'(in_sq) * QP_W'(RECIP);
    case (curve_t'(in_ctrl.code))
      CURVE_TAN:      tan_nxt = TAN1_ROM[in_mag];
      CURVE_TAN_SQ:   tan_nxt = TAN2_ROM[in_mag];
      CURVE_TAN_CUBE: tan_nxt = TAN3_ROM[in_mag];
      default:        tan_nxt = '0;
    endcase
  end

  always_comb begin
    rem = sq_c_r - SQ_W'(q0_c_r) * SQ_W'(FULL_SCALE);
    qsq = (rem >= SQ_W'(FULL_SCALE)) ? q0_c_r + MAG_W'(1) : q0_c_r;
    case (curve_t'(ctrl_c_r.code))
      CURVE_SQUARED:  curve_nxt = qsq;
      CURVE_TAN,
      CURVE_TAN_SQ,
      CURVE_TAN_CUBE: curve_nxt = tan_c_r;
      default:        curve_nxt = mag_c_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      if (ready_c) begin
        vld_c_r <= in_valid;
      end
      if (ready_d) begin
        vld_d_r <= vld_c_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && in_valid) begin
      mag_c_r  <= in_mag;
      sq_c_r   <= in_sq;
      q0_c_r   <= qprod[RECIP_SHIFT +: MAG_W];
      tan_c_r  <= tan_nxt;
      ctrl_c_r <= in_ctrl;
    end
    if (ready_d && vld_c_r) begin
      curve_d_r <= curve_nxt;
      ctrl_d_r  <= ctrl_c_r;
    end
  end

  assign out_valid = vld_d_r;
  assign out_curve = curve_d_r;
  assign out_ctrl  = ctrl_d_r;

endmodule

>>> hw/rtl/axis_response_curve_core.sv
// Axis response curve: one raw sample per cycle in while out_ready is not holding the
// output, one motion value out, through five register stages (gain product, clamp and
// square, table read and reciprocal multiply, curve select, gate and sign).
// Depends on arc_pkg, arc_scale and arc_curve.
module axis_response_curve_core import arc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_raw_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_motion_value,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  cfg_t             cfg_r;
  logic             sc_valid;
  logic             sc_ready;
  logic [MAG_W-1:0] sc_mag;
  logic [SQ_W-1:0]  sc_sq;
  ctrl_t            sc_ctrl;
  logic             cv_valid;
  logic             cv_ready;
  logic [MAG_W-1:0] cv_curve;
  ctrl_t            cv_ctrl;

  logic             vld_e_r;
  logic [OUT_W-1:0] motion_r;
  logic [OUT_W-1:0] motion_nxt;
  logic [MAG_W-1:0] clamped;
  logic [MAG_W-1:0] gated;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_sens  <= SENS_W'(256);
      cfg_r.neg_sens  <= SENS_W'(256);
      cfg_r.pos_curve <= CURVE_LINEAR;
      cfg_r.neg_curve <= CURVE_LINEAR;
      cfg_r.pos_gate  <= '0;
      cfg_r.neg_gate  <= '0;
      cfg_r.invert    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POS_SENS:  cfg_r.pos_sens  <= cfg_data;
        REG_NEG_SENS:  cfg_r.neg_sens  <= cfg_data;
        REG_POS_CURVE: cfg_r.pos_curve <= cfg_data[2:0];
        REG_NEG_CURVE: cfg_r.neg_curve <= cfg_data[2:0];
        REG_POS_GATE:  cfg_r.pos_gate  <= cfg_data[MAG_W-1:0];
        REG_NEG_GATE:  cfg_r.neg_gate  <= cfg_data[MAG_W-1:0];
        REG_INVERT:    cfg_r.invert    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  arc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_raw    (in_raw_value),
    .cfg       (cfg_r),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_mag   (sc_mag),
    .out_sq    (sc_sq),
    .out_ctrl  (sc_ctrl)
  );

  arc_curve u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_mag    (sc_mag),
    .in_sq     (sc_sq),
    .in_ctrl   (sc_ctrl),
    .out_valid (cv_valid),
    .out_ready (cv_ready),
    .out_curve (cv_curve),
    .out_ctrl  (cv_ctrl)
  );

  assign cv_ready = !vld_e_r || out_ready;

  always_comb begin
    clamped    = (cv_curve > MAG_W'(FULL_SCALE)) ? MAG_W'(FULL_SCALE) : cv_curve;
    gated      = (clamped < cv_ctrl.gate) ? '0 : clamped;
    motion_nxt = cv_ctrl.neg ? (OUT_W'(0) - OUT_W'(gated)) : OUT_W'(gated);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (cv_ready) begin
      vld_e_r <= cv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cv_ready && cv_valid) begin
      motion_r <= motion_nxt;
    end
  end

  assign out_valid        = vld_e_r;
  assign out_motion_value = signed'(motion_r);

endmodule
